>>> rtl/cezcs_pkg.sv
// Shared constants for the cell edge zero-crossing search block.
// Stream widths, field offsets and fixed-point constants.
// Used by the top level, its port checker and the testbench.
package cezcs_pkg;

    // Stream widths, fields packed from the lowest bit up, filled to whole bytes
    localparam int S_DATA_W = 328;
    localparam int M_DATA_W = 120;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int EPS_W    = 15;
    localparam int T_W      = 17;
    localparam int STEP_W   = 16;
    localparam int CORNER_W = 3;

    // Input field offsets
    localparam int CORNERS_OFS = 192;
    localparam int START_OFS   = 320;
    localparam int END_OFS     = 323;

    // Output field offsets
    localparam int FRAC_OFS = 96;

    // Fixed-point constants, Q0.17
    localparam logic [T_W-1:0]    T_INIT    = 17'd65536;
    localparam logic [STEP_W-1:0] STEP_INIT = 16'd32768;
    localparam logic [T_W:0]      U_HALF    = 18'd65536;
    localparam logic [T_W:0]      U_ONE     = 18'd131072;

    // Default number of bisection steps
    localparam int ITERATIONS_DEF = 16;

endpackage

>>> rtl/cell_edge_zero_crossing_search.sv
// Top level of the cell edge zero-crossing search block.
// Holds the sequencer, the shared four-lane blend multiplier and the result register.
// Depends on cezcs_pkg for widths, offsets and fixed-point constants.

// Usage
//   Input item (s_axis_*): one box cell: six Q16.16 bounds, eight Q4.12 corner
//   samples and a start and an end corner. The search bisects the segment
//   between the two corners until the trilinear value falls inside +/-epsilon
//   or ITERATIONS steps have run.
//   Result item (m_axis_*): crossing point x, y, z (Q16.16) and the final
//   fraction t (Q0.17).
//   cfg_we/cfg_wdata write epsilon (unsigned Q3.12); write it only while the block is idle.
// Sequence
//   Each bisection step runs three passes through the four-lane blend unit
//   (x, y, then z blends) and one decision state. The crossing point then
//   takes a multiply and an add state per axis on the same lanes. The result
//   appears as the last add completes, and the block is ready again in that
//   same cycle; it takes no new item while a search is running.
// Reset and stall
//   Reset clears epsilon to 0, drops m_axis_tvalid and returns to idle.
//   The result register decouples the sides: the next item is accepted while a
//   result waits; a new result is held back at its last add until the old
//   one is taken.
module cell_edge_zero_crossing_search #(
    parameter int ITERATIONS = cezcs_pkg::ITERATIONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // epsilon, unsigned Q3.12
    input  logic                           cfg_we,
    input  logic [cezcs_pkg::EPS_W-1:0]    cfg_wdata,
    // tdata: x_low, x_high, y_low, y_high, z_low, z_high, corners_low,
    //        corners_high, start_corner, end_corner, 2 zero bits
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cezcs_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tdata: cross_x, cross_y, cross_z, edge_fraction, 7 zero bits
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cezcs_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int ITER_W = $clog2(ITERATIONS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERATIONS - 1);
    localparam int CW = cezcs_pkg::COORD_W;
    localparam int SW = cezcs_pkg::SAMPLE_W;
    localparam int TW = cezcs_pkg::T_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X,
        ST_Y,
        ST_Z,
        ST_CHECK,
        ST_PMUL,
        ST_PADD
    } state_t;

    // Control registers
    state_t                           state_reg, state_next;
    logic                             out_valid_reg, out_valid_next;
    logic [cezcs_pkg::EPS_W-1:0]      eps_reg, eps_next;
    logic [ITER_W-1:0]                iter_reg, iter_next;
    logic [1:0]                       axis_reg, axis_next;

    // Payload registers
    logic signed [SW-1:0]             d_reg [8];
    logic signed [SW-1:0]             d_next [8];
    logic signed [SW-1:0]             c_reg [4];
    logic signed [SW-1:0]             c_next [4];
    logic signed [CW-1:0]             p0_reg [3];
    logic signed [CW-1:0]             p0_next [3];
    logic signed [CW:0]               dp_reg [3];
    logic signed [CW:0]               dp_next [3];
    logic [2:0]                       sb_reg, sb_next;
    logic [2:0]                       eb_reg, eb_next;
    logic [2:0]                       flat_reg, flat_next;
    logic [TW-1:0]                    t_reg, t_next;
    logic [cezcs_pkg::STEP_W-1:0]     step_reg, step_next;
    logic signed [CW-1:0]             pos_reg [2];
    logic signed [CW-1:0]             pos_next [2];
    logic signed [36:0]               prod_hi_reg, prod_hi_next;
    logic signed [36:0]               prod_lo_reg, prod_lo_next;
    logic [cezcs_pkg::M_DATA_W-1:0]   out_data_reg, out_data_next;

    // Shared lane unit
    logic signed [17:0]               lane_opa [4];
    logic signed [18:0]               lane_opb [4];
    logic signed [SW-1:0]             lane_base [4];
    logic signed [36:0]               lane_prod [4];
    logic signed [36:0]               lane_rnd [4];
    logic signed [SW-1:0]             lane_lerp [4];

    logic [TW:0]                      ux, uy, uz;
    logic                             below, above;
    logic signed [TW-1:0]             neg_eps;
    logic signed [53:0]               pos_sum;
    logic signed [CW-1:0]             pos_new;
    logic                             accept;
    logic                             out_free;

    // Normalized coordinate along one axis for the current t
    function automatic logic [TW:0] axis_coord(input logic sb, input logic eb,
                                               input logic flat, input logic [TW-1:0] t);
        logic [TW:0] u;
        if (flat)
            u = cezcs_pkg::U_HALF;
        else if (sb == eb)
            u = sb ? cezcs_pkg::U_ONE : '0;
        else if (sb)
            u = cezcs_pkg::U_ONE - {1'b0, t};
        else
            u = {1'b0, t};
        return u;
    endfunction

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign ux = axis_coord(sb_reg[0], eb_reg[0], flat_reg[0], t_reg);
    assign uy = axis_coord(sb_reg[1], eb_reg[1], flat_reg[1], t_reg);
    assign uz = axis_coord(sb_reg[2], eb_reg[2], flat_reg[2], t_reg);

    // Select lane operands for the current pass
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane_opa[i]  = '0;
            lane_opb[i]  = '0;
            lane_base[i] = c_reg[i];
        end
        unique case (state_reg)
            ST_X:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lane_base[i] = d_reg[i];
                    lane_opa[i]  = {{2{d_reg[i+4][SW-1]}}, d_reg[i+4]}
                                 - {{2{d_reg[i][SW-1]}}, d_reg[i]};
                    lane_opb[i]  = {1'b0, ux};
                end
            end
            ST_Y:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    lane_opa[i] = {{2{c_reg[i+2][SW-1]}}, c_reg[i+2]}
                                - {{2{c_reg[i][SW-1]}}, c_reg[i]};
                    lane_opb[i] = {1'b0, uy};
                end
            end
            ST_Z:
            begin
                lane_opa[0] = {{2{c_reg[1][SW-1]}}, c_reg[1]}
                            - {{2{c_reg[0][SW-1]}}, c_reg[0]};
                lane_opb[0] = {1'b0, uz};
            end
            ST_PMUL:
            begin
                // split the 33-bit difference: signed upper 17 bits, unsigned lower 16
                lane_opa[0] = {dp_reg[axis_reg][CW], dp_reg[axis_reg][CW:16]};
                lane_opb[0] = {2'b00, t_reg};
                lane_opa[1] = {2'b00, dp_reg[axis_reg][15:0]};
                lane_opb[1] = {2'b00, t_reg};
            end
            ST_IDLE, ST_CHECK, ST_PADD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Multiply, round to nearest and add back the base sample
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane_prod[i] = lane_opa[i] * lane_opb[i];
            lane_rnd[i]  = lane_prod[i] + 37'sd65536;
            lane_lerp[i] = lane_base[i] + lane_rnd[i][32:17];
        end
    end

    // Zero band test on the blended value
    assign neg_eps = $signed(17'd0) - $signed({2'b00, eps_reg});
    assign below   = $signed({c_reg[0][SW-1], c_reg[0]}) < neg_eps;
    assign above   = $signed({c_reg[0][SW-1], c_reg[0]}) > $signed({2'b00, eps_reg});

    // Combine partial products, round and offset from the start corner
    assign pos_sum = {prod_hi_reg[36], prod_hi_reg, 16'b0}
                   + {{17{prod_lo_reg[36]}}, prod_lo_reg}
                   + 54'sd65536;
    assign pos_new = p0_reg[axis_reg] + pos_sum[48:17];

    // Sequencer and datapath next values
    always_comb
    begin
        logic [CW-1:0] lo, hi, pe;
        lo             = '0;
        hi             = '0;
        pe             = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        eps_next       = eps_reg;
        iter_next      = iter_reg;
        axis_next      = axis_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        p0_next        = p0_reg;
        dp_next        = dp_reg;
        sb_next        = sb_reg;
        eb_next        = eb_reg;
        flat_next      = flat_reg;
        t_next         = t_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        prod_hi_next   = prod_hi_reg;
        prod_lo_next   = prod_lo_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
            eps_next = cfg_wdata;
        if (m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the cell and set up the segment
                if (accept)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        lo = s_axis_tdata[64*a +: CW];
                        hi = s_axis_tdata[64*a+32 +: CW];
                        sb_next[a]   = s_axis_tdata[cezcs_pkg::START_OFS + 2 - a];
                        eb_next[a]   = s_axis_tdata[cezcs_pkg::END_OFS + 2 - a];
                        flat_next[a] = lo == hi;
                        p0_next[a]   = sb_next[a] ? hi : lo;
                        pe           = eb_next[a] ? hi : lo;
                        dp_next[a]   = {pe[CW-1], pe} - {p0_next[a][CW-1], p0_next[a]};
                    end
                    for (int k = 0; k < 8; k++)
                        d_next[k] = s_axis_tdata[cezcs_pkg::CORNERS_OFS + SW*k +: SW];
                    t_next     = cezcs_pkg::T_INIT;
                    step_next  = cezcs_pkg::STEP_INIT;
                    iter_next  = '0;
                    state_next = ST_X;
                end
            end
            ST_X:
            begin
                for (int i = 0; i < 4; i++)
                    c_next[i] = lane_lerp[i];
                state_next = ST_Y;
            end
            ST_Y:
            begin
                c_next[0]  = lane_lerp[0];
                c_next[1]  = lane_lerp[1];
                state_next = ST_Z;
            end
            ST_Z:
            begin
                c_next[0]  = lane_lerp[0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Move t toward the crossing, or stop inside the band
                axis_next = '0;
                if (below || above)
                begin
                    t_next     = below ? t_reg + {1'b0, step_reg} : t_reg - {1'b0, step_reg};
                    step_next  = step_reg >> 1;
                    iter_next  = iter_reg + 1'b1;
                    state_next = (iter_reg == ITER_LAST) ? ST_PMUL : ST_X;
                end
                else
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                prod_hi_next = lane_prod[0];
                prod_lo_next = lane_prod[1];
                state_next   = ST_PADD;
            end
            ST_PADD:
            begin
                if (axis_reg != 2'd2)
                begin
                    pos_next[axis_reg[0]] = pos_new;
                    axis_next             = axis_reg + 1'b1;
                    state_next            = ST_PMUL;
                end
                else if (out_free)
                begin
                    // Hand the result to the output register
                    out_data_next  = {7'b0, t_reg, pos_new, pos_reg[1], pos_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, counters, epsilon and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            eps_reg       <= '0;
            iter_reg      <= '0;
            axis_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            eps_reg       <= eps_next;
            iter_reg      <= iter_next;
            axis_reg      <= axis_next;
        end
    end

    // Advance the payload registers
    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        c_reg        <= c_next;
        p0_reg       <= p0_next;
        dp_reg       <= dp_next;
        sb_reg       <= sb_next;
        eb_reg       <= eb_next;
        flat_reg     <= flat_next;
        t_reg        <= t_next;
        step_reg     <= step_next;
        pos_reg      <= pos_next;
        prod_hi_reg  <= prod_hi_next;
        prod_lo_reg  <= prod_lo_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/cezcs_checker.sv
// Port checker for the cell edge zero-crossing search block, bound to its top level.
// Watches only the stream ports; depends on cezcs_pkg for widths and offsets.
module cezcs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cezcs_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed or dropped");

    // The input stays closed while the search for a taken item runs
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken again while a search is running");

    // A new result appears only as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while the sequencer is busy");

    // Bisection never lands on t of zero, and the padding stays clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[cezcs_pkg::FRAC_OFS +: cezcs_pkg::T_W] != '0
                          && m_axis_tdata[cezcs_pkg::M_DATA_W-1:
                                          cezcs_pkg::FRAC_OFS+cezcs_pkg::T_W] == '0)
        else $error("result fraction out of range");

endmodule

bind cell_edge_zero_crossing_search cezcs_checker u_cezcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/cezcs_search_tb_pkg.sv
`timescale 1ns / 100ps
// Cell and crossing item types, the bisection search predictor and its result tracker.
// Depends on cezcs_pkg for field widths and the default step count.
package cezcs_search_tb_pkg;

    import cezcs_pkg::*;

    localparam longint Q17_ONE  = 131072;
    localparam longint Q17_HALF = 65536;

    // One input item: a box cell and the segment to search
    typedef struct packed {
        logic signed [COORD_W-1:0]  x_low;
        logic signed [COORD_W-1:0]  x_high;
        logic signed [COORD_W-1:0]  y_low;
        logic signed [COORD_W-1:0]  y_high;
        logic signed [COORD_W-1:0]  z_low;
        logic signed [COORD_W-1:0]  z_high;
        logic [4*SAMPLE_W-1:0]      corners_low;
        logic [4*SAMPLE_W-1:0]      corners_high;
        logic [CORNER_W-1:0]        start_corner;
        logic [CORNER_W-1:0]        end_corner;
    } cell_t;

    // One result item: crossing point and final fraction
    typedef struct packed {
        logic [COORD_W-1:0] cross_x;
        logic [COORD_W-1:0] cross_y;
        logic [COORD_W-1:0] cross_z;
        logic [T_W-1:0]     edge_fraction;
    } crossing_t;

    // floor((v + 0.5) / 1.0) in Q0.17
    function automatic longint round_q17(longint v);
        return (v + Q17_HALF) >>> T_W;
    endfunction

    function automatic longint blend(longint a, longint b, longint u);
        return round_q17(a * (Q17_ONE - u) + b * u);
    endfunction

    // Normalized coordinate of the current point on one axis
    function automatic longint axis_u(bit sb, bit eb, bit flat, longint t);
        if (flat)
            return Q17_HALF;
        if (sb == eb)
            return sb ? Q17_ONE : 0;
        return sb ? Q17_ONE - t : t;
    endfunction

    // Bisect until the blended sample falls inside the band or ITERATIONS_DEF steps have run
    function automatic crossing_t search_crossing(cell_t c, logic [EPS_W-1:0] eps);
        longint lo [3];
        longint hi [3];
        longint p0 [3];
        longint dp [3];
        longint d [8];
        bit sb [3];
        bit eb [3];
        bit flat [3];
        logic [SAMPLE_W-1:0] w;
        longint t, step, lim, ux, uy, uz, c0, c1, val, pos;
        bit settled;
        int a, k, it;
        crossing_t r;
        lo[0] = longint'(c.x_low);
        hi[0] = longint'(c.x_high);
        lo[1] = longint'(c.y_low);
        hi[1] = longint'(c.y_high);
        lo[2] = longint'(c.z_low);
        hi[2] = longint'(c.z_high);
        for (a = 0; a < 3; a++)
        begin
            sb[a]   = c.start_corner[2-a];
            eb[a]   = c.end_corner[2-a];
            flat[a] = lo[a] == hi[a];
            p0[a]   = sb[a] ? hi[a] : lo[a];
            dp[a]   = (eb[a] ? hi[a] : lo[a]) - p0[a];
        end
        for (k = 0; k < 8; k++)
        begin
            if (k < 4)
                w = c.corners_low[SAMPLE_W*k +: SAMPLE_W];
            else
                w = c.corners_high[SAMPLE_W*(k-4) +: SAMPLE_W];
            d[k] = longint'($signed(w));
        end
        lim     = longint'(eps);
        t       = Q17_HALF;
        step    = Q17_HALF / 2;
        settled = 1'b0;
        it      = 0;
        while (!settled && it < ITERATIONS_DEF)
        begin
            ux  = axis_u(sb[0], eb[0], flat[0], t);
            uy  = axis_u(sb[1], eb[1], flat[1], t);
            uz  = axis_u(sb[2], eb[2], flat[2], t);
            // blend along x, then y, then z
            c0  = blend(blend(d[0], d[4], ux), blend(d[2], d[6], ux), uy);
            c1  = blend(blend(d[1], d[5], ux), blend(d[3], d[7], ux), uy);
            val = blend(c0, c1, uz);
            if (val < -lim)
                t = t + step;
            else if (val > lim)
                t = t - step;
            else
                settled = 1'b1;
            step = step >>> 1;
            it++;
        end
        // position wraps to 32 bits
        pos = p0[0] + round_q17(t * dp[0]);
        r.cross_x = pos[COORD_W-1:0];
        pos = p0[1] + round_q17(t * dp[1]);
        r.cross_y = pos[COORD_W-1:0];
        pos = p0[2] + round_q17(t * dp[2]);
        r.cross_z = pos[COORD_W-1:0];
        r.edge_fraction = t[T_W-1:0];
        return r;
    endfunction

    // Holds the crossings still due, in order of acceptance
    class crossing_tracker;
        crossing_t        due_crossings [$];
        logic [EPS_W-1:0] epsilon;
        int               mismatches;
        int               cells_noted;
        int               results_checked;
        int               first_step_stops;

        function new();
            epsilon          = '0;
            mismatches       = 0;
            cells_noted      = 0;
            results_checked  = 0;
            first_step_stops = 0;
        endfunction

        function void note_cell(cell_t c);
            due_crossings.push_back(search_crossing(c, epsilon));
            cells_noted++;
        endfunction

        task report_mismatch(string what);
            if (mismatches < 25)
                $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(crossing_t got);
            crossing_t want;
            results_checked++;
            if (due_crossings.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none outstanding",
                                          results_checked));
            else
            begin
                want = due_crossings.pop_front();
                if (want.edge_fraction == Q17_HALF)
                    first_step_stops++;
                if (got.cross_x !== want.cross_x)
                    report_mismatch($sformatf("result %0d cross_x %h, want %h",
                                              results_checked, got.cross_x, want.cross_x));
                if (got.cross_y !== want.cross_y)
                    report_mismatch($sformatf("result %0d cross_y %h, want %h",
                                              results_checked, got.cross_y, want.cross_y));
                if (got.cross_z !== want.cross_z)
                    report_mismatch($sformatf("result %0d cross_z %h, want %h",
                                              results_checked, got.cross_z, want.cross_z));
                if (got.edge_fraction !== want.edge_fraction)
                    report_mismatch($sformatf("result %0d edge_fraction %h, want %h",
                                              results_checked, got.edge_fraction,
                                              want.edge_fraction));
            end
        endtask

        task close_out();
            if (due_crossings.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          due_crossings.size()));
        endtask
    endclass

endpackage

>>> sim/cell_edge_zero_crossing_search_test.sv
`timescale 1ns / 100ps
// Top of the zero-crossing search testbench: clock, reset, stream drivers and monitor.
// Depends on cezcs_pkg, cezcs_search_tb_pkg and the cell_edge_zero_crossing_search RTL.
module cell_edge_zero_crossing_search_test;

    import cezcs_pkg::*;
    import cezcs_search_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int PHASE_CELLS   = 200;
    localparam int PHASES        = 7;
    localparam int SETTLE_CYCLES = 80;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [EPS_W-1:0]    cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // tdata: x_low, x_high, y_low, y_high, z_low, z_high, corners_low,
    //        corners_high, start_corner, end_corner, 2 zero bits
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // tdata: cross_x, cross_y, cross_z, edge_fraction, 7 zero bits
    logic [M_DATA_W-1:0] m_axis_tdata;

    crossing_tracker     tracker = new();
    int                  cycle_count = 0;
    int                  burst_left = 1;
    int                  eps_writes = 0;
    int                  stall_left = 0;
    logic [31:0]         stall_pattern = '1;
    logic [EPS_W-1:0]    phase_eps [PHASES];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cell_edge_zero_crossing_search #(
        .ITERATIONS    (ITERATIONS_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: rotate a stall pattern, redrawn every window
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '1;
                1: stall_pattern = '0;
                default: stall_pattern = $urandom;
            endcase
            stall_left = $urandom_range(8, 120);
        end
        stall_left    = stall_left - 1;
        stall_pattern = {stall_pattern[30:0], stall_pattern[31]};
        m_axis_tready <= stall_pattern[0];
    end

    // Check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(split_crossing(m_axis_tdata));
    end

    function automatic logic [S_DATA_W-1:0] pack_cell(cell_t c);
        logic [S_DATA_W-1:0] v;
        v = '0;
        v[0*COORD_W +: COORD_W]         = c.x_low;
        v[1*COORD_W +: COORD_W]         = c.x_high;
        v[2*COORD_W +: COORD_W]         = c.y_low;
        v[3*COORD_W +: COORD_W]         = c.y_high;
        v[4*COORD_W +: COORD_W]         = c.z_low;
        v[5*COORD_W +: COORD_W]         = c.z_high;
        v[CORNERS_OFS +: 4*SAMPLE_W]    = c.corners_low;
        v[CORNERS_OFS + 4*SAMPLE_W +: 4*SAMPLE_W] = c.corners_high;
        v[START_OFS +: CORNER_W]        = c.start_corner;
        v[END_OFS +: CORNER_W]          = c.end_corner;
        return v;
    endfunction

    function automatic crossing_t split_crossing(logic [M_DATA_W-1:0] v);
        crossing_t r;
        r.cross_x       = v[0*COORD_W +: COORD_W];
        r.cross_y       = v[1*COORD_W +: COORD_W];
        r.cross_z       = v[2*COORD_W +: COORD_W];
        r.edge_fraction = v[FRAC_OFS +: T_W];
        return r;
    endfunction

    function automatic cell_t make_cell(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                                        logic [31:0] yh, logic [31:0] zl, logic [31:0] zh,
                                        logic [63:0] cl, logic [63:0] ch,
                                        logic [CORNER_W-1:0] s, logic [CORNER_W-1:0] e);
        cell_t c;
        c.x_low        = xl;
        c.x_high       = xh;
        c.y_low        = yl;
        c.y_high       = yh;
        c.z_low        = zl;
        c.z_high       = zh;
        c.corners_low  = cl;
        c.corners_high = ch;
        c.start_corner = s;
        c.end_corner   = e;
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode);
        logic [SAMPLE_W-1:0] v;
        if (mode == 0)
            v = SAMPLE_W'($urandom);
        else if (mode == 1)
            v = SAMPLE_W'($urandom_range(0, 8000) - 4000);
        else
            case ($urandom_range(0, 3))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                2: v = 16'h0000;
                default: v = 16'hFFFF;
            endcase
        return v;
    endfunction

    // Mostly ordinary ranges, with full random, flat, inverted and extreme bounds
    function automatic void pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
        int mode;
        logic [31:0] base, span;
        mode = $urandom_range(0, 19);
        base = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        span = $urandom_range(1, 32'h0010_0000);
        if (mode < 11)
        begin
            lo = base;
            hi = base + span;
        end
        else if (mode < 14)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (mode < 16)
        begin
            lo = $urandom;
            hi = lo;
        end
        else if (mode < 18)
        begin
            hi = base;
            lo = base + span;
        end
        else if (mode == 18)
        begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
        end
        else
        begin
            lo = 32'h7FFF_FFFF;
            hi = 32'h8000_0000;
        end
    endfunction

    // Most cells carry opposite signs at the two segment ends
    function automatic cell_t random_cell();
        cell_t c;
        logic [SAMPLE_W-1:0] d [8];
        logic [31:0] lo, hi;
        int k, mode, neg, pos;
        c.start_corner = CORNER_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0)
            c.end_corner = c.start_corner;
        else
            c.end_corner = CORNER_W'($urandom_range(0, 7));
        mode = $urandom_range(0, 9);
        for (k = 0; k < 8; k++)
            d[k] = pick_sample(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
        if (mode >= 3 && mode < 9)
        begin
            neg = $urandom_range(1, 20000);
            pos = $urandom_range(1, 20000);
            if ($urandom_range(0, 1))
            begin
                d[c.start_corner] = SAMPLE_W'(-neg);
                d[c.end_corner]   = SAMPLE_W'(pos);
            end
            else
            begin
                d[c.start_corner] = SAMPLE_W'(pos);
                d[c.end_corner]   = SAMPLE_W'(-neg);
            end
        end
        c.corners_low  = {d[3], d[2], d[1], d[0]};
        c.corners_high = {d[7], d[6], d[5], d[4]};
        pick_bounds(lo, hi);
        c.x_low  = lo;
        c.x_high = hi;
        pick_bounds(lo, hi);
        c.y_low  = lo;
        c.y_high = hi;
        pick_bounds(lo, hi);
        c.z_low  = lo;
        c.z_high = hi;
        return c;
    endfunction

    // Offer one item, hold it until taken, then maybe end the burst with a gap
    task automatic send_cell(cell_t c);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_cell(c);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_cell(c);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.due_crossings.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.epsilon = value;
        eps_writes++;
    endtask

    // Field extremes, flat and inverted cells, point segments, each corner against its opposite
    task automatic run_directed();
        logic [SAMPLE_W-1:0] d [8];
        logic [CORNER_W-1:0] s;
        int k, n;
        send_cell(make_cell(0, 0, 0, 0, 0, 0, 64'h0, 64'h0, 3'd0, 3'd7));
        send_cell(make_cell(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000,
                            64'h0000_0000_0000_F000, 64'h1000_0000_0000_0000, 3'd0, 3'd7));
        send_cell(make_cell(32'hFFFE_0000, 32'h0003_4000, 32'h0000_1000, 32'h0007_0000,
                            32'hFFFF_8000, 32'h0000_8000,
                            64'h0400_0200_0100_F000, 64'h1000_0300_FE00_0800, 3'd0, 3'd7));
        // samples pinned low or high drive t to either end
        send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF,
                            {4{16'h8000}}, {4{16'h8000}}, 3'd0, 3'd7));
        send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF,
                            {4{16'h7FFF}}, {4{16'h7FFF}}, 3'd7, 3'd0));
        // inverted bounds
        send_cell(make_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000, 32'hFFFB_0000,
                            32'h7FFF_FFFF, 32'h8000_0000,
                            64'h0C00_F400_0800_F800, 64'hF000_0600_FA00_0400, 3'd4, 3'd3));
        // point segment
        send_cell(make_cell(0, 32'h0002_0000, 0, 32'h0002_0000, 0, 32'h0002_0000,
                            64'h0100_F000_0200_0300, 64'h0500_FF00_0600_0700, 3'd5, 3'd5));
        // all axes flat, then one flat axis
        send_cell(make_cell(32'h0001_2345, 32'h0001_2345, 32'hFFFF_0000, 32'hFFFF_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            64'h0800_F800_0400_FC00, 64'hF000_1000_0200_FE00, 3'd0, 3'd7));
        send_cell(make_cell(0, 32'h0004_0000, 32'h0003_0000, 32'h0003_0000,
                            32'hFFFC_0000, 0,
                            64'h0100_0900_F200_0300, 64'hFF00_0A00_0200_F600, 3'd2, 3'd5));
        send_cell(make_cell(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000,
                            {4{16'hFFFF}}, {4{16'hFFFF}}, 3'd1, 3'd6));
        send_cell(make_cell(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000,
                            {4{16'h0001}}, {4{16'h0001}}, 3'd6, 3'd1));
        send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                            32'h0000_0000, 32'hFFFF_FFFF,
                            64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF, 3'd3, 3'd6));
        // each start corner against its opposite
        for (n = 0; n < 8; n++)
        begin
            s = CORNER_W'(n);
            for (k = 0; k < 8; k++)
                d[k] = 16'h0180;
            d[s]  = 16'hE800;
            d[~s] = 16'h0900;
            send_cell(make_cell(32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_8000,
                                32'h8000_0000, 32'h8004_0000,
                                {d[3], d[2], d[1], d[0]}, {d[7], d[6], d[5], d[4]}, s, ~s));
        end
    endtask

    initial
    begin
        int p, n;
        phase_eps[0] = '0;
        phase_eps[1] = 15'd3;
        phase_eps[2] = 15'h7FFF;
        phase_eps[3] = EPS_W'($urandom_range(0, 63));
        phase_eps[4] = 15'd1;
        phase_eps[5] = EPS_W'($urandom_range(0, 32767));
        phase_eps[6] = EPS_W'($urandom_range(64, 2047));

        // hold reset before releasing it
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_epsilon(phase_eps[p]);
            for (n = 0; n < PHASE_CELLS; n++)
                send_cell(random_cell());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.close_out();

        $display("Searched %0d cells under %0d epsilon writes; %0d results compared.",
                 tracker.cells_noted, eps_writes, tracker.results_checked);
        $display("%0d searches settled on the first step, %0d mismatches counted.",
                 tracker.first_step_stops, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cezcs_pkg.sv
rtl/cell_edge_zero_crossing_search.sv
rtl/cezcs_checker.sv
sim/cezcs_search_tb_pkg.sv
sim/cell_edge_zero_crossing_search_test.sv
